### rtl/core/sc2a_pkg.sv
`timescale 1ns / 1ps

package sc2a_pkg;

   // character ring buffer
   localparam int BUFFER_DEPTH = 256;
   localparam int IDX_W        = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

   // command queue between front and back
   localparam int CQ_DEPTH = 2;
   localparam int CQ_AW    = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
   localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

   // item kinds
   localparam logic [1:0] KIND_SCAN  = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_FLUSH = 2'd2;

   // scan codes of interest
   localparam logic [7:0] SC_LSHIFT_UP   = 8'hAA;
   localparam logic [7:0] SC_RSHIFT_UP   = 8'hB6;
   localparam logic [7:0] SC_CTRL_UP     = 8'h9D;
   localparam logic [7:0] SC_CTRL_DOWN   = 8'h1D;
   localparam logic [7:0] SC_LSHIFT_DOWN = 8'h2A;
   localparam logic [7:0] SC_RSHIFT_DOWN = 8'h36;
   localparam logic [7:0] SC_KEY_C       = 8'h2E;
   localparam logic [7:0] SC_CAPS_DOWN   = 8'h3A;
   localparam logic [7:0] SC_TABLE_SIZE  = 8'd58;
   localparam logic [6:0] CASE_OFFSET    = 7'd32;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_WRITE,
      OP_READ,
      OP_FLUSH
   } op_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] scan_byte;
      logic       process_running;
   } req_type;

   typedef struct packed {
      logic [6:0] char_out;
      logic       char_valid;
      logic       kill_request;
   } rsp_type;

   typedef struct packed {
      op_type     op;
      logic [6:0] ch;
      logic       kill;
   } cmd_type;

   function automatic logic [6:0] lower_map(input logic [5:0] code);
      logic [6:0] c;
      case (code)
         6'd2:  c = 7'h31;  6'd3:  c = 7'h32;  6'd4:  c = 7'h33;  6'd5:  c = 7'h34;
         6'd6:  c = 7'h35;  6'd7:  c = 7'h36;  6'd8:  c = 7'h37;  6'd9:  c = 7'h38;
         6'd10: c = 7'h39;  6'd11: c = 7'h30;  6'd12: c = 7'h2d;  6'd13: c = 7'h3d;
         6'd14: c = 7'h08;  6'd15: c = 7'h09;  6'd16: c = 7'h71;  6'd17: c = 7'h77;
         6'd18: c = 7'h65;  6'd19: c = 7'h72;  6'd20: c = 7'h74;  6'd21: c = 7'h79;
         6'd22: c = 7'h75;  6'd23: c = 7'h69;  6'd24: c = 7'h6f;  6'd25: c = 7'h70;
         6'd26: c = 7'h5b;  6'd27: c = 7'h5d;  6'd28: c = 7'h0a;  6'd30: c = 7'h61;
         6'd31: c = 7'h73;  6'd32: c = 7'h64;  6'd33: c = 7'h66;  6'd34: c = 7'h67;
         6'd35: c = 7'h68;  6'd36: c = 7'h6a;  6'd37: c = 7'h6b;  6'd38: c = 7'h6c;
         6'd39: c = 7'h3b;  6'd40: c = 7'h27;  6'd41: c = 7'h60;  6'd43: c = 7'h5c;
         6'd44: c = 7'h7a;  6'd45: c = 7'h78;  6'd46: c = 7'h63;  6'd47: c = 7'h76;
         6'd48: c = 7'h62;  6'd49: c = 7'h6e;  6'd50: c = 7'h6d;  6'd51: c = 7'h2c;
         6'd52: c = 7'h2e;  6'd53: c = 7'h2f;  6'd55: c = 7'h2a;  6'd57: c = 7'h20;
         default: c = 7'h00;
      endcase
      return c;
   endfunction

   function automatic logic [6:0] upper_map(input logic [5:0] code);
      logic [6:0] c;
      case (code)
         6'd2:  c = 7'h21;  6'd3:  c = 7'h40;  6'd4:  c = 7'h23;  6'd5:  c = 7'h24;
         6'd6:  c = 7'h25;  6'd7:  c = 7'h5e;  6'd8:  c = 7'h26;  6'd9:  c = 7'h2a;
         6'd10: c = 7'h28;  6'd11: c = 7'h29;  6'd12: c = 7'h5f;  6'd13: c = 7'h2b;
         6'd14: c = 7'h08;  6'd15: c = 7'h09;  6'd16: c = 7'h51;  6'd17: c = 7'h57;
         6'd18: c = 7'h45;  6'd19: c = 7'h52;  6'd20: c = 7'h54;  6'd21: c = 7'h59;
         6'd22: c = 7'h55;  6'd23: c = 7'h49;  6'd24: c = 7'h4f;  6'd25: c = 7'h50;
         6'd26: c = 7'h7b;  6'd27: c = 7'h7d;  6'd28: c = 7'h0a;  6'd30: c = 7'h41;
         6'd31: c = 7'h53;  6'd32: c = 7'h44;  6'd33: c = 7'h46;  6'd34: c = 7'h47;
         6'd35: c = 7'h48;  6'd36: c = 7'h4a;  6'd37: c = 7'h4b;  6'd38: c = 7'h4c;
         6'd39: c = 7'h3a;  6'd40: c = 7'h22;  6'd41: c = 7'h7e;  6'd43: c = 7'h7c;
         6'd44: c = 7'h5a;  6'd45: c = 7'h58;  6'd46: c = 7'h43;  6'd47: c = 7'h56;
         6'd48: c = 7'h42;  6'd49: c = 7'h4e;  6'd50: c = 7'h4d;  6'd51: c = 7'h3c;
         6'd52: c = 7'h3e;  6'd53: c = 7'h3f;  6'd55: c = 7'h2a;  6'd57: c = 7'h20;
         default: c = 7'h00;
      endcase
      return c;
   endfunction

endpackage

### rtl/core/scancode_to_ascii_key_buffer_top.sv
// an item is written into the command queue, then its result into the output register
// throughput: one item per cycle while results are popped, set by the single-port ring buffer in the back part
// the front keeps taking items while a result waits, until the two-entry command queue fills
// reset: synchronous, active high; clears modifiers, indexes, queue and the output valid flag
// the character store has no reset and is never read before it is written
`timescale 1ns / 1ps

module scancode_to_ascii_key_buffer_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  sc2a_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output sc2a_pkg::rsp_type rsp_data
);

   // front to queue
   logic              cmd_push;
   logic              cmd_full;
   sc2a_pkg::cmd_type cmd_in;

   // queue to back
   logic              cmd_valid;
   logic              cmd_pop;
   sc2a_pkg::cmd_type cmd_head;

   // front: modifier tracking and scan code to character decode
   sc2a_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .cmd_push (cmd_push),
      .cmd_full (cmd_full),
      .cmd_data (cmd_in)
   );

   // short queue so front and back stall independently
   sc2a_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .full       (cmd_full),
      .push_data  (cmd_in),
      .head_valid (cmd_valid),
      .pop        (cmd_pop),
      .head_data  (cmd_head)
   );

   // back: ring buffer, indexes and the result register
   sc2a_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_head),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

### rtl/core/sc2a_front.sv
`timescale 1ns / 1ps

module sc2a_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  sc2a_pkg::req_type req_data,
   output logic              cmd_push,
   input  logic              cmd_full,
   output sc2a_pkg::cmd_type cmd_data
);

   logic shift_held_ff, shift_held_in;
   logic ctrl_held_ff,  ctrl_held_in;
   logic caps_on_ff,    caps_on_in;
   logic accept;
   logic [7:0] b;
   logic [6:0] c;

   assign req_full = cmd_full;
   assign accept   = req_push && !cmd_full;
   assign cmd_push = accept;
   assign b        = req_data.scan_byte;

   always_comb begin
      shift_held_in = shift_held_ff;
      ctrl_held_in  = ctrl_held_ff;
      caps_on_in    = caps_on_ff;
      cmd_data.op   = sc2a_pkg::OP_NONE;
      cmd_data.ch   = 7'd0;
      cmd_data.kill = 1'b0;
      c = shift_held_ff ? sc2a_pkg::upper_map(b[5:0]) : sc2a_pkg::lower_map(b[5:0]);
      if (caps_on_ff && c >= 7'h61 && c <= 7'h7a) begin
         c = c - sc2a_pkg::CASE_OFFSET;
      end
      case (req_data.kind)
         sc2a_pkg::KIND_SCAN: begin
            if (b[7]) begin
               // release codes
               if (b == sc2a_pkg::SC_LSHIFT_UP || b == sc2a_pkg::SC_RSHIFT_UP) begin
                  shift_held_in = 1'b0;
               end
               if (b == sc2a_pkg::SC_CTRL_UP) begin
                  ctrl_held_in = 1'b0;
               end
            end else if (b == sc2a_pkg::SC_CTRL_DOWN) begin
               ctrl_held_in = 1'b1;
            end else if (b == sc2a_pkg::SC_LSHIFT_DOWN || b == sc2a_pkg::SC_RSHIFT_DOWN) begin
               shift_held_in = 1'b1;
            end else if (ctrl_held_ff && b == sc2a_pkg::SC_KEY_C) begin
               cmd_data.kill = req_data.process_running;
            end else if (b == sc2a_pkg::SC_CAPS_DOWN) begin
               caps_on_in = !caps_on_ff;
            end else if (b < sc2a_pkg::SC_TABLE_SIZE && c != 7'd0) begin
               cmd_data.op = sc2a_pkg::OP_WRITE;
               cmd_data.ch = c;
            end
         end
         sc2a_pkg::KIND_READ:  cmd_data.op = sc2a_pkg::OP_READ;
         sc2a_pkg::KIND_FLUSH: cmd_data.op = sc2a_pkg::OP_FLUSH;
         default:              cmd_data.op = sc2a_pkg::OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_held_ff <= 1'b0;
         ctrl_held_ff  <= 1'b0;
         caps_on_ff    <= 1'b0;
      end else if (accept) begin
         shift_held_ff <= shift_held_in;
         ctrl_held_ff  <= ctrl_held_in;
         caps_on_ff    <= caps_on_in;
      end
   end

endmodule

### rtl/core/sc2a_cmd_queue.sv
`timescale 1ns / 1ps

module sc2a_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  sc2a_pkg::cmd_type push_data,
   output logic              head_valid,
   input  logic              pop,
   output sc2a_pkg::cmd_type head_data
);

   localparam logic [sc2a_pkg::CQ_AW-1:0] LAST_PTR = sc2a_pkg::CQ_AW'(sc2a_pkg::CQ_DEPTH - 1);
   localparam logic [sc2a_pkg::CQ_CW-1:0] FULL_CNT = sc2a_pkg::CQ_CW'(sc2a_pkg::CQ_DEPTH);

   sc2a_pkg::cmd_type             slot_ff [sc2a_pkg::CQ_DEPTH];
   logic [sc2a_pkg::CQ_AW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [sc2a_pkg::CQ_CW-1:0]    count_ff;
   logic                          do_push, do_pop;

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

### rtl/core/sc2a_back.sv
`timescale 1ns / 1ps

module sc2a_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_pop,
   input  sc2a_pkg::cmd_type cmd_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output sc2a_pkg::rsp_type rsp_data
);

   localparam logic [sc2a_pkg::IDX_W-1:0] LAST_IDX =
      sc2a_pkg::IDX_W'(sc2a_pkg::BUFFER_DEPTH - 1);

   logic [6:0]                 char_mem [sc2a_pkg::BUFFER_DEPTH];
   logic [6:0]                 rdata_ff;
   logic [sc2a_pkg::IDX_W-1:0] rd_idx_ff, wr_idx_ff;
   logic                       out_valid_ff;
   logic                       out_char_valid_ff;
   logic                       out_kill_ff;
   logic                       issue, mem_we, mem_re;

   assign issue   = cmd_valid && (!out_valid_ff || rsp_pop);
   assign cmd_pop = issue;
   assign mem_we  = issue && cmd_data.op == sc2a_pkg::OP_WRITE;
   assign mem_re  = issue && cmd_data.op == sc2a_pkg::OP_READ && rd_idx_ff != wr_idx_ff;

   // one access per cycle, so a read never meets a write in the same cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         char_mem[wr_idx_ff] <= cmd_data.ch;
      end
      if (mem_re) begin
         rdata_ff <= char_mem[rd_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff    <= '0;
         wr_idx_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (mem_we) begin
            wr_idx_ff <= (wr_idx_ff == LAST_IDX) ? '0 : wr_idx_ff + 1'b1;
         end
         if (mem_re) begin
            rd_idx_ff <= (rd_idx_ff == LAST_IDX) ? '0 : rd_idx_ff + 1'b1;
         end else if (issue && cmd_data.op == sc2a_pkg::OP_FLUSH) begin
            rd_idx_ff <= wr_idx_ff;
         end
         if (issue) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         out_char_valid_ff <= mem_re;
         out_kill_ff       <= cmd_data.kill;
      end
   end

   assign rsp_empty             = !out_valid_ff;
   assign rsp_data.char_out     = out_char_valid_ff ? rdata_ff : 7'd0;
   assign rsp_data.char_valid   = out_char_valid_ff;
   assign rsp_data.kill_request = out_kill_ff;

endmodule

### rtl/core/sc2a_checker.sv
`timescale 1ns / 1ps

module sc2a_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_full,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input sc2a_pkg::rsp_type rsp_data
);

   // nothing to deliver and room for input right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> (rsp_empty && !req_full))
      else $error("result shown or input blocked right after reset");

   // a waiting result holds until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting result changed");

   // no character without the valid flag
   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.char_valid) |-> (rsp_data.char_out == 7'd0))
      else $error("character without valid flag");

   // only nonzero characters are ever buffered
   a_char_nonzero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.char_valid) |-> (rsp_data.char_out != 7'd0))
      else $error("zero character popped");

   // a read and a kill come from different items
   a_kill_excl: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> !(rsp_data.char_valid && rsp_data.kill_request))
      else $error("kill together with a character");

endmodule

bind scancode_to_ascii_key_buffer_top sc2a_checker u_sc2a_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);
